/* rtl/core/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope generator core.
// Holds the transaction payload structs, phase codes and the rate period table.
// No dependencies.
package adsr_pkg;

    // Phase codes carried in the result and kept in the envelope state.
    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    localparam int         PERIOD_BITS = 15;
    localparam logic [7:0] LEVEL_MAX   = 8'hFF;

    // Level breakpoints where the exponential prescaler period lengthens.
    localparam logic [7:0] BREAK_P2  = 8'd93;
    localparam logic [7:0] BREAK_P4  = 8'd54;
    localparam logic [7:0] BREAK_P8  = 8'd26;
    localparam logic [7:0] BREAK_P16 = 8'd14;
    localparam logic [7:0] BREAK_P30 = 8'd6;

    // Input transaction: one clock tick of the voice control.
    typedef struct packed {
        logic       gate;
        logic [3:0] attack_rate;
        logic [3:0] decay_rate;
        logic [3:0] sustain_level;
        logic [3:0] release_rate;
    } item_t;

    // Result transaction: envelope level and phase after the tick.
    typedef struct packed {
        logic [7:0] level;
        logic [1:0] phase;
    } result_t;

    // Envelope state other than the rate counter.
    typedef struct packed {
        logic [7:0] level;
        logic [4:0] prescale_count;
        logic [4:0] prescale_period;
        logic [1:0] phase;
        logic       last_gate;
    } env_state_t;

    // Rate counter period for each rate nibble.
    function automatic logic [PERIOD_BITS-1:0] period_lookup(input logic [3:0] idx);
        logic [PERIOD_BITS-1:0] p;
        begin
            case (idx)
                4'd0:    p = 15'd9;
                4'd1:    p = 15'd32;
                4'd2:    p = 15'd63;
                4'd3:    p = 15'd95;
                4'd4:    p = 15'd149;
                4'd5:    p = 15'd220;
                4'd6:    p = 15'd267;
                4'd7:    p = 15'd313;
                4'd8:    p = 15'd392;
                4'd9:    p = 15'd977;
                4'd10:   p = 15'd1954;
                4'd11:   p = 15'd3137;
                4'd12:   p = 15'd3922;
                4'd13:   p = 15'd11765;
                4'd14:   p = 15'd19531;
                default: p = 15'd31250;
            endcase
            return p;
        end
    endfunction

endpackage

/* rtl/core/adsr_step.sv */
// Next-state logic of the envelope for one tick.
// Depends on adsr_pkg for the state struct, phase codes and period table.
module adsr_step #(
    parameter int RATE_COUNTER_BITS = 15
) (
    input  adsr_pkg::item_t              item,
    input  adsr_pkg::env_state_t         state,
    input  logic [RATE_COUNTER_BITS-1:0] rate_count,
    output adsr_pkg::env_state_t         state_next,
    output logic [RATE_COUNTER_BITS-1:0] rate_count_next
);
    import adsr_pkg::*;

    logic [1:0]                   phase_eff;
    logic [3:0]                   rate_idx;
    logic [RATE_COUNTER_BITS-1:0] count_inc;
    logic [RATE_COUNTER_BITS-1:0] period;
    logic                         fire;
    logic [4:0]                   pcount_inc;
    logic [7:0]                   target;
    logic [7:0]                   level_dec;

    // Gate edges pick the phase before the tick is clocked.
    always_comb
    begin
        if (item.gate && !state.last_gate)
            phase_eff = PH_ATTACK;
        else if (!item.gate && state.last_gate)
            phase_eff = PH_RELEASE;
        else
            phase_eff = state.phase;
    end

    // The free-running rate counter fires only on exact match with the period.
    always_comb
    begin
        case (phase_eff)
            PH_ATTACK: rate_idx = item.attack_rate;
            PH_DECAY:  rate_idx = item.decay_rate;
            default:   rate_idx = item.release_rate;
        endcase
        period    = RATE_COUNTER_BITS'(period_lookup(rate_idx));
        count_inc = rate_count + 1'b1;
        fire      = (count_inc == period);
    end

    // Level and prescaler update.
    always_comb
    begin
        pcount_inc = state.prescale_count + 5'd1;
        target     = (phase_eff == PH_DECAY) ? {item.sustain_level, item.sustain_level}
                                             : 8'd0;
        level_dec  = state.level - 8'd1;

        state_next           = state;
        state_next.phase     = phase_eff;
        state_next.last_gate = item.gate;
        rate_count_next      = count_inc;

        if (fire)
        begin
            rate_count_next = '0;
            if (phase_eff == PH_ATTACK)
            begin
                if (state.level != LEVEL_MAX)
                    state_next.level = state.level + 8'd1;
                if (state.level >= LEVEL_MAX - 8'd1)
                begin
                    state_next.phase           = PH_DECAY;
                    state_next.prescale_count  = 5'd0;
                    state_next.prescale_period = 5'd1;
                end
            end
            else if (pcount_inc != state.prescale_period)
            begin
                state_next.prescale_count = pcount_inc;
            end
            else
            begin
                state_next.prescale_count = 5'd0;
                if (state.level != target && state.level != 8'd0)
                begin
                    state_next.level = level_dec;
                    case (level_dec)
                        BREAK_P2:  state_next.prescale_period = 5'd2;
                        BREAK_P4:  state_next.prescale_period = 5'd4;
                        BREAK_P8:  state_next.prescale_period = 5'd8;
                        BREAK_P16: state_next.prescale_period = 5'd16;
                        BREAK_P30: state_next.prescale_period = 5'd30;
                        default:   state_next.prescale_period = state.prescale_period;
                    endcase
                end
            end
        end
    end

endmodule

/* rtl/core/adsr_out_buf.sv */
// Two-entry result buffer that decouples the result channel from the input side.
// Depends on adsr_pkg for the result struct.
module adsr_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  adsr_pkg::result_t push_data,
    output logic              space,
    output logic              result_valid,
    input  logic              result_ready,
    output adsr_pkg::result_t result
);
    import adsr_pkg::*;

    result_t    slot0_reg;
    result_t    slot1_reg;
    result_t    slot0_next;
    result_t    slot1_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign result_valid = (count_reg != 2'd0);
    assign result       = slot0_reg;
    assign space        = (count_reg != 2'd2);
    assign pop          = result_valid && result_ready;

    // Head always sits in slot 0; a pop shifts slot 1 forward.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (push)
        begin
            count_next = count_next + 2'd1;
            if (count_reg == 2'd0 || (count_reg == 2'd1 && pop))
                slot0_next = push_data;
            else
                slot1_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* rtl/core/adsr_envelope_generator_core.sv */
// One voice's ADSR envelope with exponential decay and release. Each accepted
// transaction is one clock tick of the envelope and yields exactly one result
// transaction holding the level and phase after that tick. The tick is
// evaluated combinationally from the registered envelope state, so a new
// transaction is taken every cycle; results wait in a two-entry buffer, and
// input is held off only while that buffer is full. Each result is registered
// in that buffer when its transaction is accepted.
// Depends on adsr_pkg, adsr_step and adsr_out_buf.
module adsr_envelope_generator_core #(
    parameter int RATE_COUNTER_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  adsr_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output adsr_pkg::result_t result
);
    import adsr_pkg::*;

    env_state_t                   state_reg;
    env_state_t                   state_next;
    logic [RATE_COUNTER_BITS-1:0] rate_count_reg;
    logic [RATE_COUNTER_BITS-1:0] rate_count_next;
    logic                         accept;
    result_t                      step_result;

    assign accept = item_valid && item_ready;

    // Tick evaluation.
    adsr_step #(
        .RATE_COUNTER_BITS(RATE_COUNTER_BITS)
    ) u_step (
        .item            (item),
        .state           (state_reg),
        .rate_count      (rate_count_reg),
        .state_next      (state_next),
        .rate_count_next (rate_count_next)
    );

    // Envelope state advances once per accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.level           <= 8'd0;
            state_reg.prescale_count  <= 5'd0;
            state_reg.prescale_period <= 5'd1;
            state_reg.phase           <= PH_RELEASE;
            state_reg.last_gate       <= 1'b0;
            rate_count_reg            <= '0;
        end
        else if (accept)
        begin
            state_reg      <= state_next;
            rate_count_reg <= rate_count_next;
        end
    end

    assign step_result.level = state_next.level;
    assign step_result.phase = state_next.phase;

    // Result buffering.
    adsr_out_buf u_out_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (accept),
        .push_data    (step_result),
        .space        (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* tb/sv/adsr_envelope_checker.sv */
// Scoreboard for the ADSR envelope core: predicts level and phase for each tick
// transaction and compares them with the result transactions in order.
// Depends on adsr_pkg for the transaction structs and phase codes.
`timescale 1ns / 100ps

module adsr_envelope_checker #(
    parameter int RATE_BITS = 15
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic              item_ready,
    input  adsr_pkg::item_t   item,
    input  logic              result_valid,
    input  logic              result_ready,
    input  adsr_pkg::result_t result,
    output int                errors,
    output int                outstanding,
    output int                compared
);

    import adsr_pkg::*;

    // Shadow copy of the envelope state.
    logic [7:0]           level_q;
    logic [RATE_BITS-1:0] tick_count;
    logic [4:0]           step_count;
    logic [4:0]           step_period;
    logic [1:0]           phase_q;
    logic                 gate_q;

    // Predicted results still waiting for their result transaction.
    result_t env_due[$];
    result_t want;

    // Rate counter period selected by a rate nibble.
    function automatic logic [14:0] tick_period(input logic [3:0] nib);
        logic [14:0] p;
        begin
            case (nib)
                4'd0:    p = 15'd9;
                4'd1:    p = 15'd32;
                4'd2:    p = 15'd63;
                4'd3:    p = 15'd95;
                4'd4:    p = 15'd149;
                4'd5:    p = 15'd220;
                4'd6:    p = 15'd267;
                4'd7:    p = 15'd313;
                4'd8:    p = 15'd392;
                4'd9:    p = 15'd977;
                4'd10:   p = 15'd1954;
                4'd11:   p = 15'd3137;
                4'd12:   p = 15'd3922;
                4'd13:   p = 15'd11765;
                4'd14:   p = 15'd19531;
                default: p = 15'd31250;
            endcase
            return p;
        end
    endfunction

    // Advances the shadow state by one tick and returns the level and phase after it.
    function automatic result_t next_envelope(input item_t t);
        logic [3:0] nib;
        logic [7:0] floor_level;
        result_t    r;
        begin
            // Gate edges switch the phase before the tick is clocked.
            if (!gate_q && t.gate)
                phase_q = PH_ATTACK;
            else if (gate_q && !t.gate)
                phase_q = PH_RELEASE;
            gate_q = t.gate;

            case (phase_q)
                PH_ATTACK: nib = t.attack_rate;
                PH_DECAY:  nib = t.decay_rate;
                default:   nib = t.release_rate;
            endcase

            // The rate counter only fires on an exact match, so a period below
            // the current count waits for the counter to wrap.
            tick_count = tick_count + 1'b1;
            if (tick_count == RATE_BITS'(tick_period(nib))) begin
                tick_count = '0;
                if (phase_q == PH_ATTACK) begin
                    if (level_q != LEVEL_MAX)
                        level_q = level_q + 8'd1;
                    if (level_q == LEVEL_MAX) begin
                        phase_q     = PH_DECAY;
                        step_count  = 5'd0;
                        step_period = 5'd1;
                    end
                end else begin
                    step_count = step_count + 5'd1;
                    if (step_count == step_period) begin
                        step_count  = 5'd0;
                        floor_level = (phase_q == PH_DECAY) ?
                                      {4'd0, t.sustain_level} * 8'd17 : 8'd0;
                        if (level_q != floor_level && level_q != 8'd0) begin
                            level_q = level_q - 8'd1;
                            // The prescaler slows down at the exponential breakpoints.
                            case (level_q)
                                BREAK_P2:  step_period = 5'd2;
                                BREAK_P4:  step_period = 5'd4;
                                BREAK_P8:  step_period = 5'd8;
                                BREAK_P16: step_period = 5'd16;
                                BREAK_P30: step_period = 5'd30;
                                default:   ;
                            endcase
                        end
                    end
                end
            end

            r.level = level_q;
            r.phase = phase_q;
            return r;
        end
    endfunction

    // Predict on every accepted tick and compare every accepted result.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            level_q     = 8'd0;
            tick_count  = '0;
            step_count  = 5'd0;
            step_period = 5'd1;
            phase_q     = PH_RELEASE;
            gate_q      = 1'b0;
            env_due.delete();
            outstanding = 0;
        end else begin
            if (item_valid && item_ready)
                env_due.push_back(next_envelope(item));

            if (result_valid && result_ready) begin
                if (env_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with no tick outstanding: level %0d phase %0d",
                             $time, result.level, result.phase);
                end else begin
                    want = env_due.pop_front();
                    compared++;
                    if (result.level !== want.level) begin
                        errors++;
                        $display("%0t: level mismatch: expected %0d, got %0d",
                                 $time, want.level, result.level);
                    end
                    if (result.phase !== want.phase) begin
                        errors++;
                        $display("%0t: phase mismatch: expected %0d, got %0d",
                                 $time, want.phase, result.phase);
                    end
                end
            end

            outstanding = env_due.size();
        end
    end

endmodule

/* tb/sv/tb_adsr_envelope_generator_core.sv */
// Top of the ADSR envelope core testbench: clock, reset, tick stimulus with
// random idling on both channels, and the final verdict.
// Depends on adsr_pkg, the core RTL and adsr_envelope_checker.
`timescale 1ns / 100ps

module tb_adsr_envelope_generator_core;

    import adsr_pkg::*;

    // The long note climbs partway up at the fastest attack rate, and its
    // release then runs past the breakpoint at 26 where the prescaler slows.
    localparam int SWEEP_GATE_TICKS    = 300;
    localparam int SWEEP_RELEASE_TICKS = 360;
    localparam int RANDOM_TICKS        = 320;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    int errors;
    int outstanding;
    int compared;
    int ticks_sent = 0;
    int notes      = 0;
    bit quiet      = 1'b0;

    // 12 ns clock period.
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    adsr_envelope_generator_core #(
        .RATE_COUNTER_BITS(15)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    adsr_envelope_checker #(
        .RATE_BITS(15)
    ) env_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .errors      (errors),
        .outstanding (outstanding),
        .compared    (compared)
    );

    function automatic item_t tick_fields(input logic g, input logic [3:0] a,
                                          input logic [3:0] d, input logic [3:0] s,
                                          input logic [3:0] r);
        item_t t;
        begin
            t.gate          = g;
            t.attack_rate   = a;
            t.decay_rate    = d;
            t.sustain_level = s;
            t.release_rate  = r;
            return t;
        end
    endfunction

    // Fast rates most of the time so that the counter fires often.
    function automatic logic [3:0] pick_rate();
        begin
            if ($urandom_range(0, 3) != 0)
                return 4'($urandom_range(0, 2));
            return 4'($urandom_range(0, 15));
        end
    endfunction

    function automatic logic [3:0] any_nibble();
        begin
            return 4'($urandom_range(0, 15));
        end
    endfunction

    // Sends one tick transaction after a random gap and waits for its acceptance.
    task automatic send_tick(input item_t t);
        int gap;
        begin
            gap = quiet ? 0 : $urandom_range(0, 7);
            @(negedge clk);
            if (gap != 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            item       <= t;
            item_valid <= 1'b1;
            do @(posedge clk); while (!item_ready);
            ticks_sent++;
        end
    endtask

    // Lowers valid after the last accepted transaction and waits for the results.
    task automatic drain();
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            while (outstanding != 0) @(negedge clk);
        end
    endtask

    // Result side: a random stall before each result transaction.
    initial begin : result_sink
        int stall;
        @(negedge clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                result_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ready <= 1'b1;
            do @(posedge clk); while (!result_valid);
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial begin : stimulus
        int         n;
        int         i;
        int         len_on;
        int         len_off;
        logic [3:0] ar;
        logic [3:0] dr;
        logic [3:0] sl;
        logic [3:0] rr;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed ticks: field extremes, gate edges both ways, a first attack
        // step, a release step back to zero and a fire held off by a long period.
        send_tick(tick_fields(1'b0, 4'd0, 4'd0, 4'd0, 4'd0));
        send_tick(tick_fields(1'b0, 4'd15, 4'd15, 4'd15, 4'd15));
        repeat (9) send_tick(tick_fields(1'b1, 4'd0, 4'd15, 4'd15, 4'd15));
        send_tick(tick_fields(1'b0, 4'd15, 4'd15, 4'd8, 4'd0));
        send_tick(tick_fields(1'b1, 4'd15, 4'd0, 4'd0, 4'd0));
        repeat (10) send_tick(tick_fields(1'b0, any_nibble(), any_nibble(),
                                          any_nibble(), 4'd0));

        // Let every result arrive before the long note starts.
        drain();

        // One long note at the fastest attack rate, then its release at the
        // fastest rate. The rate counter is below the shortest period here,
        // so the first fire comes on time.
        for (n = 0; n < SWEEP_GATE_TICKS; n++) begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            send_tick(tick_fields(1'b1, 4'd0, 4'd0, any_nibble(), any_nibble()));
        end
        for (n = 0; n < SWEEP_RELEASE_TICKS; n++) begin
            if (n % 100 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            send_tick(tick_fields(1'b0, any_nibble(), any_nibble(), any_nibble(), 4'd0));
        end
        notes = 1;

        // Random notes with occasional sustain changes, plus bursts of noise.
        n = 0;
        while (n < RANDOM_TICKS) begin
            quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) begin
                len_on = $urandom_range(1, 20);
                for (i = 0; i < len_on; i++)
                    send_tick(tick_fields(1'($urandom), any_nibble(), any_nibble(),
                                          any_nibble(), any_nibble()));
                n += len_on;
            end else begin
                ar      = pick_rate();
                dr      = pick_rate();
                rr      = pick_rate();
                sl      = any_nibble();
                len_on  = $urandom_range(1, 120);
                len_off = $urandom_range(1, 80);
                for (i = 0; i < len_on; i++) begin
                    if ($urandom_range(0, 15) == 0)
                        sl = any_nibble();
                    send_tick(tick_fields(1'b1, ar, dr, sl, rr));
                end
                for (i = 0; i < len_off; i++) begin
                    if ($urandom_range(0, 31) == 0)
                        rr = pick_rate();
                    send_tick(tick_fields(1'b0, ar, dr, sl, rr));
                end
                n += len_on + len_off;
                notes++;
            end
        end
        quiet = 1'b0;

        // Wait out the results.
        drain();
        repeat (4) @(negedge clk);

        $display("Run covered %0d ticks: directed gate edges, one long fast note and",
                 ticks_sent);
        $display("%0d notes in all with noise bursts and random idling; %0d results compared.",
                 notes, compared);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Generous bound on the whole run.
    initial begin : watchdog
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
